@@ rtl/irle_pkg.sv @@
// ----------------------------------------------------------------------------
// irle_pkg
// shared types and constants for the index range leb128 encoder
// ----------------------------------------------------------------------------
package irle_pkg;

    localparam int IDX_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int GROUP_W   = 7;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    // one run to be serialized: start, extra count and the flags of its last byte
    typedef struct packed {
        logic [IDX_W-1:0] start;
        logic [IDX_W-1:0] extra;
        logic             step_last;
        logic             list_done;
    } run_entry_t;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

endpackage

@@ rtl/irle_front.sv @@
// ----------------------------------------------------------------------------
// irle_front
// run tracking: extends the open run or queues runs to be emitted
// ----------------------------------------------------------------------------
module irle_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [irle_pkg::IDX_W-1:0] index_value,
    input  logic                      final_value,
    input  irle_pkg::q_status_t       q_stat,
    output logic                      push,
    output irle_pkg::run_entry_t      push_data
);

    logic                        run_open_reg, run_open_next;
    logic [irle_pkg::IDX_W-1:0]  run_start_reg, run_start_next;
    logic [irle_pkg::IDX_W-1:0]  run_extra_reg, run_extra_next;
    logic                        pend_valid_reg, pend_valid_next;
    irle_pkg::run_entry_t        pend_entry_reg, pend_entry_next;

    logic                        accept;
    logic                        close_run;
    logic                        extend_run;
    logic [irle_pkg::IDX_W-1:0]  expect_val;
    irle_pkg::run_entry_t        entry_close;
    irle_pkg::run_entry_t        entry_fin;

    assign in_stall   = pend_valid_reg || q_stat.full;
    assign accept     = in_valid && !in_stall;
    assign expect_val = run_start_reg + run_extra_reg + irle_pkg::IDX_W'(1);
    assign close_run  = run_open_reg && (index_value != expect_val);
    assign extend_run = run_open_reg && !close_run;

    always_comb
    begin
        run_start_next = extend_run ? run_start_reg : index_value;
        run_extra_next = extend_run ? run_extra_reg + irle_pkg::IDX_W'(1) : '0;

        entry_close.start     = run_start_reg;
        entry_close.extra     = run_extra_reg;
        entry_close.step_last = !final_value;
        entry_close.list_done = 1'b0;

        entry_fin.start       = run_start_next;
        entry_fin.extra       = run_extra_next;
        entry_fin.step_last   = 1'b1;
        entry_fin.list_done   = 1'b1;

        run_open_next   = run_open_reg;
        pend_valid_next = pend_valid_reg;
        pend_entry_next = pend_entry_reg;

        if (pend_valid_reg)
        begin
            push      = !q_stat.full;
            push_data = pend_entry_reg;
            if (!q_stat.full)
            begin
                pend_valid_next = 1'b0;
            end
        end
        else
        begin
            push      = accept && (close_run || final_value);
            push_data = close_run ? entry_close : entry_fin;
        end

        if (accept)
        begin
            run_open_next = !final_value;
            if (close_run && final_value)
            begin
                // flush run waits in the pending register behind the closed run
                pend_valid_next = 1'b1;
                pend_entry_next = entry_fin;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            run_open_reg   <= run_open_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            run_start_reg <= run_start_next;
            run_extra_reg <= run_extra_next;
        end
        pend_entry_reg <= pend_entry_next;
    end

endmodule

@@ rtl/irle_fifo.sv @@
// ----------------------------------------------------------------------------
// irle_fifo
// short run queue between the front and the serializer
// ----------------------------------------------------------------------------
module irle_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  irle_pkg::run_entry_t push_data,
    input  logic                 pop,
    output irle_pkg::q_status_t  q_stat,
    output irle_pkg::run_entry_t head
);

    irle_pkg::run_entry_t         mem_reg [irle_pkg::QDEPTH];
    logic [irle_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [irle_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [irle_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                         do_push;
    logic                         do_pop;

    assign q_stat.full  = (count_reg == irle_pkg::QCNT_W'(irle_pkg::QDEPTH));
    assign q_stat.valid = (count_reg != '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && q_stat.valid;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + irle_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + irle_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + irle_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - irle_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/irle_back.sv @@
// ----------------------------------------------------------------------------
// irle_back
// leb128 serializer: one byte per cycle while the receiver does not stall, into a registered output
// ----------------------------------------------------------------------------
module irle_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  irle_pkg::q_status_t           q_stat,
    input  irle_pkg::run_entry_t          head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [irle_pkg::BYTE_W-1:0]   out_byte,
    output logic                          step_last,
    output logic                          list_done
);

    logic                          busy_reg, busy_next;
    logic                          phase_reg, phase_next;     // 0 start, 1 extra
    logic [irle_pkg::IDX_W-1:0]    cur_reg, cur_next;
    logic [irle_pkg::IDX_W-1:0]    extra_reg, extra_next;
    logic                          last_reg, last_next;
    logic                          done_reg, done_next;

    logic                          out_valid_reg, out_valid_next;
    logic [irle_pkg::BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                          step_last_reg, step_last_next;
    logic                          list_done_reg, list_done_next;

    logic                          advance;
    logic                          emit;
    logic                          more;
    logic                          finish;

    assign advance = !out_valid_reg || !out_stall;
    assign emit    = busy_reg && advance;
    assign more    = |cur_reg[irle_pkg::IDX_W-1:irle_pkg::GROUP_W];
    assign finish  = emit && !more && phase_reg;
    assign pop     = q_stat.valid && (!busy_reg || finish);

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        cur_next   = cur_reg;
        extra_next = extra_reg;
        last_next  = last_reg;
        done_next  = done_reg;

        if (pop)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            cur_next   = head.start;
            extra_next = head.extra;
            last_next  = head.step_last;
            done_next  = head.list_done;
        end
        else if (emit)
        begin
            if (more)
            begin
                cur_next = cur_reg >> irle_pkg::GROUP_W;
            end
            else if (!phase_reg)
            begin
                cur_next   = extra_reg;
                phase_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end

        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        step_last_next = step_last_reg;
        list_done_next = list_done_reg;
        if (advance)
        begin
            out_valid_next = emit;
            out_byte_next  = {more, cur_reg[irle_pkg::GROUP_W-1:0]};
            step_last_next = !more && phase_reg && last_reg;
            list_done_next = !more && phase_reg && done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg     <= phase_next;
        cur_reg       <= cur_next;
        extra_reg     <= extra_next;
        last_reg      <= last_next;
        done_reg      <= done_next;
        out_byte_reg  <= out_byte_next;
        step_last_reg <= step_last_next;
        list_done_reg <= list_done_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign step_last = step_last_reg;
    assign list_done = list_done_reg;

endmodule

@@ rtl/index_range_leb128_encoder.sv @@
// ----------------------------------------------------------------------------
// index_range_leb128_encoder
// groups ascending indexes into runs and emits each run as two uleb128 numbers
// ----------------------------------------------------------------------------
// path: with an idle serializer the first byte of a queued run passes the run queue,
// the serializer's run registers and the output byte register; throughput: one input
// per cycle while runs only extend and the run queue is not full; a closed run costs
// 2 to 10 output bytes, a close plus flush up to 20, set by the byte-wide serializer;
// the 4-entry run queue absorbs bursts of closes
// reset: rst_n asynchronous active low clears run, queue and output valid state
module index_range_leb128_encoder
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input transaction: one index
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [irle_pkg::IDX_W-1:0]    index_value,
    input  logic                          final_value,
    // output transaction: one encoded byte
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [irle_pkg::BYTE_W-1:0]   out_byte,
    output logic                          step_last,
    output logic                          list_done
);

    // front to queue
    logic                 push;
    irle_pkg::run_entry_t push_data;
    // queue status to both sides, head and pop between the queue and the back
    irle_pkg::q_status_t  q_stat;
    irle_pkg::run_entry_t head;
    logic                 pop;

    // front: tracks the open run, decides close / extend / flush, queues runs
    irle_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .index_value (index_value),
        .final_value (final_value),
        .q_stat      (q_stat),
        .push        (push),
        .push_data   (push_data)
    );

    // run queue decouples input acceptance from byte serialization
    irle_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .q_stat    (q_stat),
        .head      (head)
    );

    // back: start then extra count, 7 bits per byte, lsb group first
    irle_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .step_last (step_last),
        .list_done (list_done)
    );

endmodule

@@ rtl/irle_checker.sv @@
// ----------------------------------------------------------------------------
// irle_checker
// port-level checks for the index range leb128 encoder
// ----------------------------------------------------------------------------
module irle_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [irle_pkg::IDX_W-1:0]    index_value,
    input  logic                          final_value,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [irle_pkg::BYTE_W-1:0]   out_byte,
    input  logic                          step_last,
    input  logic                          list_done
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(step_last) && $stable(list_done))
        else $error("stalled output changed");

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(index_value)
            && $stable(final_value))
        else $error("stalled input changed");

    // end of list is always the end of a step
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && list_done |-> step_last)
        else $error("list_done without step_last");

    // last byte of a step ends a number, so no continuation bit
    a_last_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && step_last |-> !out_byte[irle_pkg::BYTE_W-1])
        else $error("continuation bit on last byte");

    // no output transaction is offered right after reset
    a_reset_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind index_range_leb128_encoder irle_checker u_irle_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .index_value (index_value),
    .final_value (final_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .step_last   (step_last),
    .list_done   (list_done)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the index range uleb128 encoder byte by byte against a local predictor;
// a short table of directed indexes comes first, then random ascending lists
// with duplicates and out-of-order noise, under bursty input and output stalls
// ----------------------------------------------------------------------------
module tb;

    localparam int ROWS        = 23;
    localparam int RANDOM_N    = 290;
    localparam int HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT = 1500;

    // one encoded byte with its two flags
    typedef struct packed {
        logic [irle_pkg::BYTE_W-1:0] data;
        logic                        step_last;
        logic                        list_done;
    } enc_byte_t;

    // one directed transaction; known_n < 0 leaves the expected bytes to the predictor,
    // otherwise known_bytes holds known_n bytes, first byte in the low bits
    typedef struct packed {
        logic [irle_pkg::IDX_W-1:0] value;
        logic                       fin;
        logic signed [7:0]          known_n;
        logic [159:0]               known_bytes;
    } index_row_t;

    // receiver stall patterns
    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [irle_pkg::IDX_W-1:0]  index_value;
    logic                        final_value;
    logic                        out_valid;
    logic                        out_stall;
    logic [irle_pkg::BYTE_W-1:0] out_byte;
    logic                        step_last;
    logic                        list_done;

    // predictor copy of the run being collected
    logic                       open_run;
    logic [irle_pkg::IDX_W-1:0] run_base;
    logic [irle_pkg::IDX_W-1:0] run_more;

    enc_byte_t  step_bytes[$];      // bytes caused by the transaction being predicted
    enc_byte_t  pending_bytes[$];   // bytes predicted and not yet seen on the output
    enc_byte_t  want;
    enc_byte_t  tail;

    index_row_t index_rows [ROWS];
    int         cur_known;
    logic [159:0] cur_bytes;

    int mismatches;
    int items_sent;
    int stuck_cycles;
    int burst_left;
    bit hold_req;

    index_range_leb128_encoder uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .index_value (index_value),
        .final_value (final_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .step_last   (step_last),
        .list_done   (list_done)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // one number as uleb128: low 7-bit group first, bit 7 marks more to come
    function automatic void append_leb(input logic [irle_pkg::IDX_W-1:0] num);
        logic [irle_pkg::IDX_W-1:0] rest;
        enc_byte_t                  eb;
        rest = num;
        do
        begin
            eb.data      = {1'b0, rest[irle_pkg::GROUP_W-1:0]};
            rest         = rest >> irle_pkg::GROUP_W;
            eb.data[7]   = (rest != '0);
            eb.step_last = 1'b0;
            eb.list_done = 1'b0;
            step_bytes.push_back(eb);
        end
        while (rest != '0);
    endfunction

    // run bookkeeping for one index; leaves the unflagged bytes in step_bytes
    function automatic void encode_index(input logic [irle_pkg::IDX_W-1:0] v,
                                         input logic fin);
        step_bytes.delete();
        if (!open_run)
        begin
            run_base = v;
            run_more = '0;
        end
        else if (v == run_base + run_more + 32'd1)
        begin
            // consecutive value, wraps past the top of the range
            run_more = run_more + 32'd1;
        end
        else
        begin
            // gap, duplicate or step back: the open run goes out
            append_leb(run_base);
            append_leb(run_more);
            run_base = v;
            run_more = '0;
        end
        if (fin)
        begin
            append_leb(run_base);
            append_leb(run_more);
        end
        open_run = !fin;
    endfunction

    task automatic report(input string what, input logic [31:0] exp_v,
                          input logic [31:0] act_v);
        mismatches++;
        $display("%0t: %s expected %0h actual %0h", $time, what, exp_v, act_v);
    endtask

    // ------------------------------------------------------------------
    // monitor: predicts on each input transaction, checks each output one
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                encode_index(index_value, final_value);
                // directed rows with bytes typed in replace the predicted ones
                if (cur_known >= 0)
                begin
                    step_bytes.delete();
                    for (int i = 0; i < cur_known; i++)
                    begin
                        tail.data      = cur_bytes[8*i +: 8];
                        tail.step_last = 1'b0;
                        tail.list_done = 1'b0;
                        step_bytes.push_back(tail);
                    end
                end
                // flags sit on the last byte of the transaction only
                if (step_bytes.size() > 0)
                begin
                    tail           = step_bytes.pop_back();
                    tail.step_last = 1'b1;
                    tail.list_done = final_value;
                    step_bytes.push_back(tail);
                end
                foreach (step_bytes[i])
                    pending_bytes.push_back(step_bytes[i]);
            end

            if (out_valid && !out_stall)
            begin
                if (pending_bytes.size() == 0)
                begin
                    report("unexpected byte, out_byte", 32'h0, {24'h0, out_byte});
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    if (out_byte !== want.data)
                        report("out_byte", {24'h0, want.data}, {24'h0, out_byte});
                    if (step_last !== want.step_last)
                        report("step_last", {31'h0, want.step_last}, {31'h0, step_last});
                    if (list_done !== want.list_done)
                        report("list_done", {31'h0, want.list_done}, {31'h0, list_done});
                end
            end

            // watchdog input: cycles with no transaction on either side
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
    end

    // watchdog
    initial
    begin
        stuck_cycles = 0;
        wait (rst_n === 1'b1);
        while (stuck_cycles < STUCK_LIMIT)
            @(negedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: changing stall patterns plus one long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        rx_mode_t rx_mode;
        int       mode_left;
        int       held;
        bit       hold_done;
        out_stall = 1'b0;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        held      = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                // block stays stalled long enough for the run queue to fill
                out_stall <= 1'b1;
                held++;
                if (held == HOLD_CYCLES)
                    hold_done = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:   out_stall <= 1'b0;
                    RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
                    RX_TOGGLE: out_stall <= ~out_stall;
                    default:   out_stall <= 1'b0;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------

    // offer one index with its expected bytes and hold it until the block takes it
    task automatic send_index(input logic [irle_pkg::IDX_W-1:0] v, input logic fin,
                              input int known, input logic [159:0] kbytes);
        @(negedge clk);
        in_valid    <= 1'b1;
        index_value <= v;
        final_value <= fin;
        cur_known   <= known;
        cur_bytes   <= kbytes;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // bursts of random length, random gaps between them, some gapless stretches
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // drop valid and wait until every predicted byte has come out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(negedge clk);
    endtask

    // index of random magnitude, sometimes right under the wrap point
    function automatic logic [irle_pkg::IDX_W-1:0] rand_index();
        int          sel;
        logic [63:0] mask;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return $urandom;
        if (sel == 1)
            return 32'hFFFF_FFFF - $urandom_range(0, 20);
        mask = (64'd1 << $urandom_range(1, 32)) - 64'd1;
        return $urandom & mask[irle_pkg::IDX_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [irle_pkg::IDX_W-1:0] cursor;
        int                         n_runs;
        int                         run_len;
        logic                       fin;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        index_value = '0;
        final_value = 1'b0;
        open_run    = 1'b0;
        run_base    = '0;
        run_more    = '0;
        mismatches  = 0;
        items_sent  = 0;
        burst_left  = 0;
        hold_req    = 1'b0;
        cur_known   = -1;
        cur_bytes   = '0;

        index_rows = '{
            // single value flushed at once, lowest and highest index
            '{32'h0000_0000, 1'b1,  8'sd2, 160'h0000},
            '{32'hFFFF_FFFF, 1'b1,  8'sd6, 160'h00_0F_FF_FF_FF_FF},
            // run 5..7 closed by a duplicate
            '{32'h0000_0005, 1'b0,  8'sd0, 160'h0},
            '{32'h0000_0006, 1'b0,  8'sd0, 160'h0},
            '{32'h0000_0007, 1'b0,  8'sd0, 160'h0},
            '{32'h0000_0007, 1'b0,  8'sd2, 160'h0205},
            // step back closes the duplicate's run
            '{32'h0000_0003, 1'b0,  8'sd2, 160'h0007},
            '{32'h0000_0080, 1'b0,  8'sd2, 160'h0003},
            '{32'h0000_0081, 1'b0,  8'sd0, 160'h0},
            // close and flush in one transaction, two-byte numbers
            '{32'h0000_3FFF, 1'b1,  8'sd6, 160'h00_7F_FF_01_01_80},
            // run that wraps past the top of the index range
            '{32'hFFFF_FFFE, 1'b0,  8'sd0, 160'h0},
            '{32'hFFFF_FFFF, 1'b0,  8'sd0, 160'h0},
            '{32'h0000_0000, 1'b0,  8'sd0, 160'h0},
            '{32'h0000_0001, 1'b1,  8'sd6, 160'h03_0F_FF_FF_FF_FE},
            // two five-byte starts in one transaction
            '{32'hFFFF_FFF0, 1'b0, -8'sd1, 160'h0},
            '{32'h1000_0000, 1'b1, -8'sd1, 160'h0},
            // alternating bit patterns
            '{32'h5555_5555, 1'b0, -8'sd1, 160'h0},
            '{32'hAAAA_AAAA, 1'b1, -8'sd1, 160'h0},
            // largest one-byte group, then three-byte start extended by the final
            '{32'h0000_007F, 1'b1,  8'sd2, 160'h007F},
            '{32'h0000_4000, 1'b0,  8'sd0, 160'h0},
            '{32'h0000_4001, 1'b1,  8'sd4, 160'h01_01_80_80},
            // duplicate on the final transaction: close and flush
            '{32'h1234_5678, 1'b0, -8'sd1, 160'h0},
            '{32'h1234_5678, 1'b1, -8'sd1, 160'h0}
        };

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed table
        foreach (index_rows[i])
        begin
            send_index(index_rows[i].value, index_rows[i].fin,
                       int'(index_rows[i].known_n), index_rows[i].known_bytes);
            pace();
        end

        // sender pauses until the block has emptied out
        drain();

        // long output hold-off starts while random lists keep coming
        hold_req = 1'b1;

        // random ascending lists of runs, with duplicates and noise mixed in
        while (items_sent < ROWS + RANDOM_N)
        begin
            n_runs = $urandom_range(1, 5);
            cursor = rand_index();
            for (int r = 0; r < n_runs; r++)
            begin
                run_len = $urandom_range(1, 10);
                for (int k = 0; k < run_len; k++)
                begin
                    // most lists end on a final, a few run into the next list
                    fin = (r == n_runs - 1 && k == run_len - 1) && ($urandom_range(0, 9) != 0);
                    send_index(cursor, fin, -1, '0);
                    pace();
                    if ($urandom_range(0, 15) == 0)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            send_index(cursor, 1'b0, -1, '0);
                        else
                            send_index(rand_index(), ($urandom_range(0, 7) == 0), -1, '0);
                        pace();
                    end
                    cursor = cursor + 32'd1;
                end
                // jump to the next run, past the consecutive value unless the random jump wraps
                if ($urandom_range(0, 3) == 0)
                    cursor = cursor + 32'd1 + (rand_index() >> $urandom_range(0, 31));
                else
                    cursor = cursor + 32'd1 + $urandom_range(1, 200);
            end
        end

        // wait out the tail and the pipeline latency
        drain();
        repeat (30) @(negedge clk);

        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
